/* hw/rtl/ksm_pkg.sv */
// Shared types and constants for the keyed position smoother.
// Holds the request payload structs, table entry layout and code constants.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ksm_pkg;

    localparam int DT_W     = 10;
    localparam int DT_STEPS = 1 << DT_W;
    localparam int ALPHA_W  = 17;

    localparam logic KIND_LOOKUP = 1'b0;
    localparam logic KIND_TICK   = 1'b1;

    localparam logic [1:0] OUTCOME_NEW    = 2'd0;
    localparam logic [1:0] OUTCOME_SNAP   = 2'd1;
    localparam logic [1:0] OUTCOME_SMOOTH = 2'd2;

    localparam logic [30:0] SNAP_RESET = 31'd327680;

    typedef logic [DT_STEPS-1:0][ALPHA_W-1:0] alpha_rom_t;

    typedef struct packed {
        logic               kind;
        logic [31:0]        object_id;
        logic signed [31:0] target_x;
        logic signed [31:0] target_y;
        logic signed [31:0] target_z;
        logic [DT_W-1:0]    dt;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] out_x;
        logic signed [31:0] out_y;
        logic signed [31:0] out_z;
        logic [1:0]         outcome;
        logic [3:0]         slot_index;
    } out_item_t;

    typedef struct packed {
        logic [31:0]      id;
        logic [31:0]      last_seen;
        logic [2:0][31:0] pos;
    } entry_t;

endpackage

`default_nettype wire

/* hw/rtl/keyed_position_smoother.sv */
// Top level of the keyed position smoother: slot table sweep, snap test and
// exponential smoothing. Depends on ksm_pkg and ksm_ram.
//
//  channel | signals                       | payload
//  --------+-------------------------------+---------------------------
//  in      | in_valid / in_ready           | ksm_pkg::in_item_t
//  out     | out_valid / out_ready         | ksm_pkg::out_item_t
//  cfg     | cfg_valid / cfg_ready         | cfg_data (snap distance)
//
// A tick request only advances the clock and produces nothing. A lookup request
// reads the table RAM one slot per cycle and then allocates a slot on a miss;
// on a hit one shared 31x31 multiplier squares three axes and the snap
// distance, then, unless the request snaps, a 33x17 multiplier smooths three
// axes, and the slot is written back.
// rst_n clears the valid bits and clock and presets the snap register at once;
// the table RAM needs no clearing pass. A stalled output holds in its register
// while the next request is taken; only the write-back step waits for it.
`timescale 1ns / 1ps
`default_nettype none

module keyed_position_smoother #(
    parameter int SLOTS     = 16,
    parameter int TAU_TICKS = 410
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire ksm_pkg::in_item_t  in_item,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output ksm_pkg::out_item_t      out_item,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [30:0]        cfg_data
);

    localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    localparam logic [3:0] ST_IDLE     = 4'd0;
    localparam logic [3:0] ST_SWEEP    = 4'd1;
    localparam logic [3:0] ST_DECIDE   = 4'd2;
    localparam logic [3:0] ST_SQ_MUL   = 4'd3;
    localparam logic [3:0] ST_SQ_ACC   = 4'd4;
    localparam logic [3:0] ST_SNAP_MUL = 4'd5;
    localparam logic [3:0] ST_SNAP_CMP = 4'd6;
    localparam logic [3:0] ST_SM_MUL   = 4'd7;
    localparam logic [3:0] ST_SM_ACC   = 4'd8;
    localparam logic [3:0] ST_WRITE    = 4'd9;

    // exp(-v / 2^30) in Q0.30 by a 15-term series
    function automatic logic [63:0] exp_neg_q30(input logic [63:0] v);
        logic [63:0] term;
        logic [63:0] sum;
        term = 64'd1 << 30;
        sum  = 64'd1 << 30;
        for (int k = 1; k <= 14; k++)
        begin
            term = ((term * v) >> 30) / 64'(k);
            if (k % 2 == 1)
            begin
                sum = sum - term;
            end
            else
            begin
                sum = sum + term;
            end
        end
        return sum;
    endfunction

    // alpha = 1 - exp(-dt / TAU_TICKS) in Q1.16, 65536 meaning one
    function automatic ksm_pkg::alpha_rom_t build_alpha_rom();
        ksm_pkg::alpha_rom_t rom;
        logic [63:0] e1;
        logic [63:0] x;
        logic [63:0] n;
        logic [63:0] e;
        e1 = exp_neg_q30(64'd1 << 30);
        for (int dt = 0; dt < ksm_pkg::DT_STEPS; dt++)
        begin
            x = (64'(dt) << 30) / 64'(TAU_TICKS);
            n = x >> 30;
            if (n > 64'd40)
            begin
                e = 64'd0;
            end
            else
            begin
                e = exp_neg_q30(x & ((64'd1 << 30) - 64'd1));
                for (int i = 0; i < 41; i++)
                begin
                    if (64'(i) < n)
                    begin
                        e = (e * e1) >> 30;
                    end
                end
            end
            rom[dt] = ksm_pkg::ALPHA_W'(64'd65536 - ((e * 64'd65536 + (64'd1 << 29)) >> 30));
        end
        return rom;
    endfunction

    localparam ksm_pkg::alpha_rom_t ALPHA_ROM = build_alpha_rom();

    // control state
    logic [3:0]       state_reg, state_next;
    logic [31:0]      clock_reg, clock_next;
    logic [30:0]      snap_reg, snap_next;
    logic [SLOTS-1:0] valid_reg, valid_next;
    logic [SW:0]      issue_cnt_reg, issue_cnt_next;
    logic             pend_vld_reg, pend_vld_next;
    logic             hit_reg, hit_next;
    logic             empty_found_reg, empty_found_next;
    logic             far_reg, far_next;
    logic [1:0]       ax_reg, ax_next;
    logic             out_valid_reg, out_valid_next;

    // payload
    ksm_pkg::in_item_t   item_reg, item_next;
    logic [ksm_pkg::ALPHA_W-1:0] alpha_reg, alpha_next;
    logic [SW-1:0]       pend_idx_reg, pend_idx_next;
    logic [SW-1:0]       hit_idx_reg, hit_idx_next;
    logic [SW-1:0]       empty_idx_reg, empty_idx_next;
    logic [SW-1:0]       old_idx_reg, old_idx_next;
    logic [31:0]         old_ls_reg, old_ls_next;
    logic [2:0][31:0]    hit_pos_reg, hit_pos_next;
    logic signed [32:0]  d_reg [3];
    logic signed [32:0]  d_next [3];
    logic [61:0]         sq_reg, sq_next;
    logic [63:0]         sum_reg, sum_next;
    logic signed [50:0]  sm_reg, sm_next;
    logic [2:0][31:0]    new_pos_reg, new_pos_next;
    logic [SW-1:0]       slot_reg, slot_next;
    logic [1:0]          outcome_reg, outcome_next;
    ksm_pkg::out_item_t  out_item_reg, out_item_next;

    // table RAM
    logic            ram_we;
    logic [SW-1:0]   ram_waddr;
    ksm_pkg::entry_t ram_wdata;
    logic [SW-1:0]   ram_raddr;
    logic [$bits(ksm_pkg::entry_t)-1:0] ram_rdata;
    ksm_pkg::entry_t rd_entry;

    logic               in_acc;
    logic [2:0][31:0]   tgt;
    logic [32:0]        clock_sum;
    logic [32:0]        mag;
    logic signed [32:0] d_sel;
    logic signed [50:0] sm_round;
    logic [SW+3:0]      slot_wide;

    ksm_ram #(
        .WIDTH ($bits(ksm_pkg::entry_t)),
        .DEPTH (SLOTS)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rd_entry  = ksm_pkg::entry_t'(ram_rdata);
    assign in_ready  = (state_reg == ST_IDLE);
    assign in_acc    = in_valid && in_ready;
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    assign tgt[0] = item_reg.target_x;
    assign tgt[1] = item_reg.target_y;
    assign tgt[2] = item_reg.target_z;

    assign clock_sum = {1'b0, clock_reg} + {23'd0, in_item.dt};
    assign d_sel     = d_reg[ax_reg];
    assign mag       = d_sel[32] ? 33'(-d_sel) : 33'(d_sel);
    assign sm_round  = (sm_reg + 51'sd32768) >>> 16;
    assign slot_wide = {4'd0, slot_reg};

    always_comb
    begin
        state_next       = state_reg;
        clock_next       = clock_reg;
        snap_next        = snap_reg;
        valid_next       = valid_reg;
        issue_cnt_next   = issue_cnt_reg;
        pend_vld_next    = pend_vld_reg;
        hit_next         = hit_reg;
        empty_found_next = empty_found_reg;
        far_next         = far_reg;
        ax_next          = ax_reg;
        out_valid_next   = out_valid_reg;
        item_next        = item_reg;
        // read the alpha ROM at the held dt; the registered word is ready
        // long before smoothing starts
        alpha_next       = ALPHA_ROM[item_reg.dt];
        pend_idx_next    = pend_idx_reg;
        hit_idx_next     = hit_idx_reg;
        empty_idx_next   = empty_idx_reg;
        old_idx_next     = old_idx_reg;
        old_ls_next      = old_ls_reg;
        hit_pos_next     = hit_pos_reg;
        d_next           = d_reg;
        sq_next          = sq_reg;
        sum_next         = sum_reg;
        sm_next          = sm_reg;
        new_pos_next     = new_pos_reg;
        slot_next        = slot_reg;
        outcome_next     = outcome_reg;
        out_item_next    = out_item_reg;
        ram_we           = 1'b0;
        ram_waddr        = slot_reg;
        ram_wdata        = '{id: item_reg.object_id, last_seen: clock_reg, pos: new_pos_reg};
        ram_raddr        = issue_cnt_reg[SW-1:0];

        if (cfg_valid && cfg_ready)
        begin
            snap_next = cfg_data;
        end

        // drop the output once taken
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    if (in_item.kind == ksm_pkg::KIND_TICK)
                    begin
                        clock_next = clock_sum[32] ? 32'hFFFF_FFFF : clock_sum[31:0];
                    end
                    else
                    begin
                        item_next        = in_item;
                        issue_cnt_next   = '0;
                        pend_vld_next    = 1'b0;
                        hit_next         = 1'b0;
                        empty_found_next = 1'b0;
                        state_next       = ST_SWEEP;
                    end
                end
            end
            ST_SWEEP:
            begin
                // issue one read per cycle, check the previous one
                if (issue_cnt_reg < (SW+1)'(SLOTS))
                begin
                    issue_cnt_next = issue_cnt_reg + 1'b1;
                    pend_vld_next  = 1'b1;
                    pend_idx_next  = issue_cnt_reg[SW-1:0];
                end
                else
                begin
                    pend_vld_next = 1'b0;
                end
                if (pend_vld_reg)
                begin
                    if (valid_reg[pend_idx_reg] && !hit_reg
                        && rd_entry.id == item_reg.object_id)
                    begin
                        hit_next     = 1'b1;
                        hit_idx_next = pend_idx_reg;
                        hit_pos_next = rd_entry.pos;
                    end
                    if (!valid_reg[pend_idx_reg] && !empty_found_reg)
                    begin
                        empty_found_next = 1'b1;
                        empty_idx_next   = pend_idx_reg;
                    end
                    if (pend_idx_reg == '0 || rd_entry.last_seen < old_ls_reg)
                    begin
                        old_idx_next = pend_idx_reg;
                        old_ls_next  = rd_entry.last_seen;
                    end
                    if (pend_idx_reg == SW'(SLOTS - 1))
                    begin
                        state_next = ST_DECIDE;
                    end
                end
            end
            ST_DECIDE:
            begin
                if (hit_reg)
                begin
                    for (int a = 0; a < 3; a++)
                    begin
                        d_next[a] = $signed({tgt[a][31], tgt[a]})
                                  - $signed({hit_pos_reg[a][31], hit_pos_reg[a]});
                    end
                    far_next   = 1'b0;
                    sum_next   = '0;
                    ax_next    = '0;
                    state_next = ST_SQ_MUL;
                end
                else
                begin
                    slot_next    = empty_found_reg ? empty_idx_reg : old_idx_reg;
                    new_pos_next = tgt;
                    outcome_next = ksm_pkg::OUTCOME_NEW;
                    state_next   = ST_WRITE;
                end
            end
            ST_SQ_MUL:
            begin
                if (mag > {2'b00, snap_reg})
                begin
                    far_next = 1'b1;
                end
                sq_next    = mag[30:0] * mag[30:0];
                state_next = ST_SQ_ACC;
            end
            ST_SQ_ACC:
            begin
                sum_next = sum_reg + {2'b00, sq_reg};
                if (ax_reg == 2'd2)
                begin
                    state_next = ST_SNAP_MUL;
                end
                else
                begin
                    ax_next    = ax_reg + 1'b1;
                    state_next = ST_SQ_MUL;
                end
            end
            ST_SNAP_MUL:
            begin
                sq_next    = snap_reg * snap_reg;
                state_next = ST_SNAP_CMP;
            end
            ST_SNAP_CMP:
            begin
                slot_next = hit_idx_reg;
                if (far_reg || sum_reg > {2'b00, sq_reg})
                begin
                    new_pos_next = tgt;
                    outcome_next = ksm_pkg::OUTCOME_SNAP;
                    state_next   = ST_WRITE;
                end
                else
                begin
                    ax_next    = '0;
                    state_next = ST_SM_MUL;
                end
            end
            ST_SM_MUL:
            begin
                sm_next    = 51'(d_sel * $signed({1'b0, alpha_reg}));
                state_next = ST_SM_ACC;
            end
            ST_SM_ACC:
            begin
                new_pos_next[ax_reg] = hit_pos_reg[ax_reg] + sm_round[31:0];
                if (ax_reg == 2'd2)
                begin
                    outcome_next = ksm_pkg::OUTCOME_SMOOTH;
                    state_next   = ST_WRITE;
                end
                else
                begin
                    ax_next    = ax_reg + 1'b1;
                    state_next = ST_SM_MUL;
                end
            end
            ST_WRITE:
            begin
                // rewriting the same entry while the output stalls is harmless
                ram_we             = 1'b1;
                valid_next[slot_reg] = 1'b1;
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    out_item_next  = '{out_x: new_pos_reg[0], out_y: new_pos_reg[1],
                                       out_z: new_pos_reg[2], outcome: outcome_reg,
                                       slot_index: slot_wide[3:0]};
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            clock_reg       <= '0;
            snap_reg        <= ksm_pkg::SNAP_RESET;
            valid_reg       <= '0;
            issue_cnt_reg   <= '0;
            pend_vld_reg    <= 1'b0;
            hit_reg         <= 1'b0;
            empty_found_reg <= 1'b0;
            far_reg         <= 1'b0;
            ax_reg          <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            clock_reg       <= clock_next;
            snap_reg        <= snap_next;
            valid_reg       <= valid_next;
            issue_cnt_reg   <= issue_cnt_next;
            pend_vld_reg    <= pend_vld_next;
            hit_reg         <= hit_next;
            empty_found_reg <= empty_found_next;
            far_reg         <= far_next;
            ax_reg          <= ax_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg      <= item_next;
        alpha_reg     <= alpha_next;
        pend_idx_reg  <= pend_idx_next;
        hit_idx_reg   <= hit_idx_next;
        empty_idx_reg <= empty_idx_next;
        old_idx_reg   <= old_idx_next;
        old_ls_reg    <= old_ls_next;
        hit_pos_reg   <= hit_pos_next;
        d_reg         <= d_next;
        sq_reg        <= sq_next;
        sum_reg       <= sum_next;
        sm_reg        <= sm_next;
        new_pos_reg   <= new_pos_next;
        slot_reg      <= slot_next;
        outcome_reg   <= outcome_next;
        out_item_reg  <= out_item_next;
    end

`ifndef NO_ASSERTIONS
    a_tick_no_work: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && in_item.kind == ksm_pkg::KIND_TICK) |=> state_reg == ST_IDLE)
        else $error("tick request started table work");

    a_sweep_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_SWEEP |-> issue_cnt_reg <= (SW+1)'(SLOTS))
        else $error("sweep read past the last slot");

    a_write_slot: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_WRITE |-> (SW+1)'(slot_reg) < (SW+1)'(SLOTS))
        else $error("write-back slot out of range");

    a_outcome_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_item_reg.outcome == ksm_pkg::OUTCOME_NEW
            || out_item_reg.outcome == ksm_pkg::OUTCOME_SNAP
            || out_item_reg.outcome == ksm_pkg::OUTCOME_SMOOTH))
        else $error("result carries an unknown outcome");

    a_valid_after_write: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WRITE) |=> valid_reg[$past(slot_reg)])
        else $error("written slot not marked valid");
`endif

endmodule

`default_nettype wire

/* hw/rtl/ksm_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module ksm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                    clk,
    input  wire logic                                    we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                        wdata,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

/* tb/tb.sv */
// Self-checking bench for keyed_position_smoother: random and directed lookups and ticks.
// Depends on ksm_pkg and the keyed_position_smoother RTL.
`timescale 1ns / 1ps

module tb;

    localparam int SLOTS     = 16;
    localparam int TAU_TICKS = 410;
    localparam int WATCHDOG  = 20000;

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_ready;
    ksm_pkg::in_item_t   in_item;
    logic                out_valid;
    logic                out_ready;
    ksm_pkg::out_item_t  out_item;
    logic                cfg_valid;
    logic                cfg_ready;
    logic [30:0]         cfg_data;

    keyed_position_smoother #(.SLOTS(SLOTS), .TAU_TICKS(TAU_TICKS)) dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
        .out_valid(out_valid), .out_ready(out_ready), .out_item(out_item),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    // Predictor state: mirrors the slot table, clock and snap register.
    logic [16:0]  alpha_table [ksm_pkg::DT_STEPS];
    bit           slot_used [SLOTS];
    logic [31:0]  slot_id [SLOTS];
    logic [31:0]  slot_seen [SLOTS];
    logic [31:0]  slot_pos [SLOTS][3];
    logic [31:0]  tick_clock;
    logic [30:0]  snap_reg;

    ksm_pkg::in_item_t   pending_requests[$];
    ksm_pkg::out_item_t  expected_positions[$];
    int           fail_count;
    int           idle_cycles;
    int           in_wait;
    int           out_wait;
    bit           cfg_request;
    logic [30:0]  cfg_request_data;
    bit           drive_enable;

    initial clk = 1'b0;
    always #10 clk = ~clk;

    // Truncated Taylor series for exp(-v/2^30), Q0.30.
    function automatic longint unsigned exp_series(longint unsigned v);
        longint unsigned term;
        longint unsigned sum;
        term = 64'd1 << 30;
        sum  = 64'd1 << 30;
        for (int k = 1; k <= 14; k++) begin
            term = ((term * v) >> 30) / k;
            if (k % 2 == 1) sum = sum - term;
            else sum = sum + term;
        end
        return sum;
    endfunction

    task automatic build_alpha_table();
        longint unsigned e_one;
        longint unsigned x;
        longint unsigned n;
        longint unsigned e;
        e_one = exp_series(64'd1 << 30);
        for (int d = 0; d < ksm_pkg::DT_STEPS; d++) begin
            x = (longint'(d) << 30) / TAU_TICKS;
            n = x >> 30;
            if (n > 40) e = 0;
            else begin
                e = exp_series(x & ((64'd1 << 30) - 1));
                for (int i = 0; i < n; i++) e = (e * e_one) >> 30;
            end
            alpha_table[d] = 17'(65536 - ((e * 65536 + (64'd1 << 29)) >> 30));
        end
    endtask

    function automatic longint floor_shift16(longint p);
        if (p >= 0) return p >>> 16;
        return -((-p + 65535) >>> 16);
    endfunction

    // Apply one request to the predictor; queue the expected result.
    task automatic predict_request(ksm_pkg::in_item_t req);
        int           slot;
        int           free_slot;
        int           oldest;
        longint       tgt [3];
        longint       delta [3];
        longint unsigned mag;
        longint unsigned sum_sq;
        longint unsigned snap;
        bit           far;
        logic [1:0]   result_code;
        ksm_pkg::out_item_t res;
        longint unsigned c;
        slot = -1;
        if (req.kind == ksm_pkg::KIND_TICK) begin
            c = longint'(tick_clock) + req.dt;
            tick_clock = (c > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : c[31:0];
            return;
        end
        tgt[0] = longint'(req.target_x);
        tgt[1] = longint'(req.target_y);
        tgt[2] = longint'(req.target_z);
        for (int i = 0; i < SLOTS; i++)
            if (slot < 0 && slot_used[i] && slot_id[i] == req.object_id) slot = i;
        if (slot < 0) begin
            free_slot = -1;
            oldest = 0;
            for (int i = 0; i < SLOTS; i++) begin
                if (!slot_used[i] && free_slot < 0) free_slot = i;
                if (slot_seen[i] < slot_seen[oldest]) oldest = i;
            end
            slot = (free_slot >= 0) ? free_slot : oldest;
            slot_used[slot] = 1'b1;
            slot_id[slot] = req.object_id;
            for (int a = 0; a < 3; a++) slot_pos[slot][a] = tgt[a][31:0];
            result_code = ksm_pkg::OUTCOME_NEW;
        end else begin
            snap = snap_reg;
            sum_sq = 0;
            far = 1'b0;
            for (int a = 0; a < 3; a++) begin
                delta[a] = tgt[a] - longint'(signed'(slot_pos[slot][a]));
                mag = (delta[a] < 0) ? -delta[a] : delta[a];
                if (mag > snap) far = 1'b1;
                else sum_sq = sum_sq + mag * mag;
            end
            if (far || sum_sq > snap * snap) begin
                for (int a = 0; a < 3; a++) slot_pos[slot][a] = tgt[a][31:0];
                result_code = ksm_pkg::OUTCOME_SNAP;
            end else begin
                for (int a = 0; a < 3; a++)
                    slot_pos[slot][a] = 32'(longint'(signed'(slot_pos[slot][a]))
                        + floor_shift16(delta[a] * longint'(alpha_table[req.dt]) + 32768));
                result_code = ksm_pkg::OUTCOME_SMOOTH;
            end
        end
        slot_seen[slot] = tick_clock;
        res.out_x = slot_pos[slot][0];
        res.out_y = slot_pos[slot][1];
        res.out_z = slot_pos[slot][2];
        res.outcome = result_code;
        res.slot_index = 4'(slot);
        expected_positions.push_back(res);
    endtask

    // Driver: hold each request until accepted, then wait a random gap.
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
            in_item  <= '0;
            in_wait  <= 0;
        end else if (in_valid && !in_ready) begin
            // hold
        end else if (in_valid && in_ready) begin
            predict_request(in_item);
            in_valid <= 1'b0;
            in_wait  <= $urandom_range(0, 19);
        end else if (in_wait > 0) begin
            in_wait <= in_wait - 1;
        end else if (drive_enable && pending_requests.size() > 0) begin
            in_item  <= pending_requests.pop_front();
            in_valid <= 1'b1;
        end
    end

    // Monitor: compare each result with the oldest expectation.
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            out_ready <= 1'b0;
            out_wait  <= 0;
        end else begin
            if (out_valid && out_ready) begin
                if (expected_positions.size() == 0) begin
                    $display("%0t: unexpected result %p", $time, out_item);
                    fail_count++;
                end else begin
                    ksm_pkg::out_item_t want;
                    want = expected_positions.pop_front();
                    if (want !== out_item) begin
                        $display("%0t: mismatch expected %p actual %p", $time, want, out_item);
                        fail_count++;
                    end
                end
            end
            if (out_wait > 0) begin
                out_wait  <= out_wait - 1;
                out_ready <= 1'b0;
            end else if (out_valid && out_ready) begin
                out_wait  <= $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 19);
                out_ready <= 1'b0;
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    // Config channel: raise valid on request, drop after the write lands.
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            cfg_valid <= 1'b0;
            cfg_data  <= '0;
        end else if (cfg_valid && cfg_ready) begin
            snap_reg  <= cfg_data;
            cfg_valid <= 1'b0;
        end else if (!cfg_valid && cfg_request) begin
            cfg_data  <= cfg_request_data;
            cfg_valid <= 1'b1;
        end
    end

    // Watchdog: count cycles with no accepted request of any kind.
    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)
            || !drive_enable)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCHDOG) begin
            $display("Some tests failed");
            $finish;
        end
    end

    function automatic ksm_pkg::in_item_t make_lookup(logic [31:0] id, logic [31:0] x,
                                                      logic [31:0] y, logic [31:0] z,
                                                      logic [9:0] dt);
        ksm_pkg::in_item_t r;
        r.kind = ksm_pkg::KIND_LOOKUP;
        r.object_id = id;
        r.target_x = x;
        r.target_y = y;
        r.target_z = z;
        r.dt = dt;
        return r;
    endfunction

    function automatic ksm_pkg::in_item_t make_tick(logic [9:0] dt);
        ksm_pkg::in_item_t r;
        r = make_lookup($urandom, $urandom, $urandom, $urandom, dt);
        r.kind = ksm_pkg::KIND_TICK;
        return r;
    endfunction

    // Drain the pipeline, then let the block settle before touching config.
    task automatic wait_drained();
        while (pending_requests.size() > 0 || in_valid || expected_positions.size() > 0)
            @(posedge clk);
        repeat (SLOTS + 40) @(posedge clk);
    endtask

    task automatic write_snap(logic [30:0] value);
        cfg_request_data = value;
        cfg_request = 1'b1;
        @(posedge clk);
        while (!(cfg_valid && cfg_ready)) @(posedge clk);
        cfg_request = 1'b0;
        @(posedge clk);
    endtask

    // Random phase: a small id pool so hits dominate, jitter near the
    // previous target so both smoothing and snapping occur.
    task automatic random_phase(int count);
        logic [31:0] pool [8];
        logic [31:0] last [8][3];
        int          k;
        int          r;
        logic [31:0] jitter;
        for (int i = 0; i < 8; i++) begin
            pool[i] = $urandom;
            for (int a = 0; a < 3; a++) last[i][a] = $urandom;
        end
        for (int n = 0; n < count; n++) begin
            r = $urandom_range(0, 99);
            if (r < 12) begin
                pending_requests.push_back(make_tick($urandom_range(0, 3) == 0 ?
                    10'h3FF : 10'($urandom)));
            end else if (r < 22) begin
                pending_requests.push_back(make_lookup($urandom, $urandom, $urandom,
                    $urandom, 10'($urandom)));
            end else begin
                k = (r < 40) ? $urandom_range(0, 7) : $urandom_range(0, 4);
                for (int a = 0; a < 3; a++) begin
                    jitter = $urandom_range(0, 3) == 0 ? $urandom : 32'($urandom_range(0, 1 << 19))
                        - 32'(1 << 18);
                    last[k][a] = last[k][a] + jitter;
                end
                pending_requests.push_back(make_lookup(pool[k], last[k][0], last[k][1],
                    last[k][2], 10'($urandom)));
            end
        end
    endtask

    initial begin
        fail_count = 0;
        idle_cycles = 0;
        cfg_request = 1'b0;
        cfg_request_data = '0;
        drive_enable = 1'b0;
        tick_clock = '0;
        snap_reg = ksm_pkg::SNAP_RESET;
        for (int i = 0; i < SLOTS; i++) begin
            slot_used[i] = 1'b0;
            slot_seen[i] = '0;
        end
        build_alpha_table();
        rst_n = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: allocate, hit with tiny and huge moves, dt extremes,
        // fill the table and evict the stalest.
        pending_requests.push_back(make_lookup(32'h0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 10'd0));
        pending_requests.push_back(make_lookup(32'h0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 10'd0));
        pending_requests.push_back(make_lookup(32'h0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0,
                                               10'h3FF));
        pending_requests.push_back(make_lookup(32'hFFFF_FFFF, 32'h0001_0000, 32'h0, 32'h0, 10'd1));
        pending_requests.push_back(make_lookup(32'hFFFF_FFFF, 32'h0002_0000, 32'h0001_0000,
                                               32'hFFFF_0000, 10'h3FF));
        pending_requests.push_back(make_lookup(32'hFFFF_FFFF, 32'h0006_0000, 32'h0, 32'h0, 10'd5));
        pending_requests.push_back(make_tick(10'h3FF));
        for (int i = 0; i < 16; i++)
            pending_requests.push_back(make_lookup(32'h100 + i, $urandom, $urandom, $urandom,
                                                   10'($urandom)));
        pending_requests.push_back(make_tick(10'h155));
        pending_requests.push_back(make_lookup(32'hAAAA_5555, 32'h5555_AAAA, 32'hAAAA_5555,
                                               32'h5555_AAAA, 10'h2AA));
        drive_enable = 1'b1;
        wait_drained();

        write_snap(31'h7FFF_FFFF);
        random_phase(300);
        wait_drained();
        write_snap(31'd0);
        random_phase(250);
        wait_drained();
        write_snap(31'd65536);
        random_phase(300);
        // Push the clock toward saturation with a run of long ticks.
        for (int i = 0; i < 40; i++) pending_requests.push_back(make_tick(10'h3FF));
        wait_drained();
        tick_clock = tick_clock;
        write_snap(31'($urandom_range(1 << 16, 1 << 22)));
        random_phase(400);
        wait_drained();

        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule
